### rtl/mtf_pkg.sv
package mtf_pkg;

	// Parser phase between bytes.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DATA1 = 2'd1,
		PH_DATA2 = 2'd2,
		PH_SYSEX = 2'd3
	} phase_t;

	// Status high nibbles that open channel messages.
	localparam logic [3:0] NIB_NOTE_OFF   = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON    = 4'h9;
	localparam logic [3:0] NIB_POLY_PRESS = 4'hA;
	localparam logic [3:0] NIB_CTRL       = 4'hB;
	localparam logic [3:0] NIB_PROG       = 4'hC;
	localparam logic [3:0] NIB_CHAN_PRESS = 4'hD;
	localparam logic [3:0] NIB_PITCH      = 4'hE;

	localparam logic [7:0] SYSEX_START = 8'hF0;
	localparam logic [7:0] SYSEX_END   = 8'hF7;

	// Widest message length the result fields can carry.
	localparam int unsigned LEN_CEIL = 4096;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [11:0] position;
		logic        is_last;
		logic [12:0] msg_length;
		logic        is_sysex;
	} result_t;

endpackage

### rtl/mtf_byte_if.sv
interface mtf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

### rtl/mtf_msg_if.sv
interface mtf_msg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [11:0] position;
	logic        is_last;
	logic [12:0] msg_length;
	logic        is_sysex;

	modport source (output valid, output data_byte, output position, output is_last,
		output msg_length, output is_sysex, input ready);
	modport sink (input valid, input data_byte, input position, input is_last,
		input msg_length, input is_sysex, output ready);
endinterface

### rtl/mtf_in_stage.sv
module mtf_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	mtf_byte_if.sink   byte_in,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	import mtf_pkg::*;

	// A new byte may enter when the register is empty or the held one leaves in the same cycle.
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1 <= byte_in.in_byte;
		end
	end
endmodule

### rtl/mtf_parser.sv
module mtf_parser #(
	parameter int unsigned MAX_SYSEX = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic [7:0]      byte_s1,
	output logic            emit,
	output mtf_pkg::result_t res
);
	import mtf_pkg::*;

	// Effective system-exclusive limit: at most the widest length, at least two.
	localparam int unsigned CAP_HI = (MAX_SYSEX > LEN_CEIL) ? LEN_CEIL : MAX_SYSEX;
	localparam int unsigned CAP    = (CAP_HI < 2) ? 2 : CAP_HI;
	localparam logic [12:0] CAP_W  = 13'(CAP);

	phase_t      phase_q, phase_d;
	logic        three_q, three_d;
	logic [12:0] count_q, count_d;
	logic [3:0]  hi;
	logic [11:0] sx_pos;
	logic [12:0] sx_len;

	assign hi     = byte_s1[7:4];
	assign sx_pos = (count_q > 13'(LEN_CEIL - 1)) ? 12'(LEN_CEIL - 1) : count_q[11:0];
	assign sx_len = {1'b0, sx_pos} + 13'd1;

	always_comb begin
		phase_d        = phase_q;
		three_d        = three_q;
		count_d        = count_q;
		emit           = 1'b0;
		res.data_byte  = byte_s1;
		res.position   = 12'd0;
		res.is_last    = 1'b0;
		res.msg_length = 13'd0;
		res.is_sysex   = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (hi inside {NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL,
						NIB_PITCH}) begin
					emit    = 1'b1;
					three_d = 1'b1;
					phase_d = PH_DATA1;
				end else if (hi inside {NIB_PROG, NIB_CHAN_PRESS}) begin
					emit    = 1'b1;
					three_d = 1'b0;
					phase_d = PH_DATA1;
				end else if (byte_s1 == SYSEX_START) begin
					emit         = 1'b1;
					res.is_sysex = 1'b1;
					count_d      = 13'd1;
					phase_d      = PH_SYSEX;
				end
			end
			PH_DATA1: begin
				emit         = 1'b1;
				res.position = 12'd1;
				if (three_q) begin
					phase_d = PH_DATA2;
				end else begin
					res.is_last    = 1'b1;
					res.msg_length = 13'd2;
					phase_d        = PH_IDLE;
				end
			end
			PH_DATA2: begin
				emit           = 1'b1;
				res.position   = 12'd2;
				res.is_last    = 1'b1;
				res.msg_length = 13'd3;
				phase_d        = PH_IDLE;
			end
			PH_SYSEX: begin
				// Stray status bytes inside system-exclusive are skipped.
				if (!byte_s1[7] || byte_s1 == SYSEX_END) begin
					emit         = 1'b1;
					res.is_sysex = 1'b1;
					res.position = sx_pos;
					if (byte_s1 == SYSEX_END || sx_len >= CAP_W) begin
						res.is_last    = 1'b1;
						res.msg_length = sx_len;
						count_d        = 13'd0;
						phase_d        = PH_IDLE;
					end else begin
						count_d = sx_len;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			three_q <= 1'b0;
			count_q <= 13'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			three_q <= three_d;
			count_q <= count_d;
		end
	end
endmodule

### rtl/mtf_out_stage.sv
module mtf_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  logic             emit,
	input  mtf_pkg::result_t res,
	output logic             advance,
	mtf_msg_if.source        msg_out
);
	import mtf_pkg::*;

	logic    valid_q;
	logic    free;
	result_t res_q;

	// The slot is free when empty or when its result is taken this cycle.
	assign free    = !valid_q || msg_out.ready;
	assign advance = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign msg_out.valid      = valid_q;
	assign msg_out.data_byte  = res_q.data_byte;
	assign msg_out.position   = res_q.position;
	assign msg_out.is_last    = res_q.is_last;
	assign msg_out.msg_length = res_q.msg_length;
	assign msg_out.is_sysex   = res_q.is_sysex;
endmodule

### rtl/midi_tx_message_framer.sv
// MIDI transmit message framer.
// The byte_in channel takes one byte of the transmit stream per request. The
// msg_out channel gives one request for every byte that belongs to a framed
// message, with its position in the message, a last flag, the total length on
// the last byte and a system-exclusive flag. Bytes that open nothing while
// idle, and status bytes inside system-exclusive, are consumed silently.
// A byte accepted on byte_in is held in the input register and parsed from
// there; its result is latched in the result register, which offers it on
// msg_out. Throughput: one byte per cycle while the receiver does not stall,
// set by the single parser pass between the input register and the result
// register.
// When the receiver stalls, the result register holds its request and the
// input register holds one more byte; byte_in.ready drops only when both are
// full. Parser state advances only when a byte leaves the input register.
// Reset clears both valid flags and puts the parser in idle, awaiting a status
// byte with no message open. System-exclusive messages end on 0xF7 or when
// they reach MAX_SYSEX bytes (clamped to at least 2 and never more than 4096).
module midi_tx_message_framer #(
	parameter int unsigned MAX_SYSEX = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	mtf_byte_if.sink  byte_in,
	mtf_msg_if.source msg_out
);
	import mtf_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       emit;
	result_t    res;

	// Input register: one byte waiting for the parser.
	mtf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Parser: message state and the framing decision for the held byte.
	mtf_parser #(
		.MAX_SYSEX (MAX_SYSEX)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	// Result register: decides when the held byte may move on.
	mtf_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.emit     (emit),
		.res      (res),
		.advance  (advance),
		.msg_out  (msg_out)
	);
endmodule

### rtl/mtf_checker.sv
module mtf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  data_byte,
	input logic [11:0] position,
	input logic        is_last,
	input logic [12:0] msg_length,
	input logic        is_sysex
);
	// Length is reported on the last byte and only there.
	a_len_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_last == (msg_length != 13'd0)))
		else $error("msg_length does not follow is_last");

	// The last byte's position is one less than the length.
	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |-> (msg_length == {1'b0, position} + 13'd1))
		else $error("msg_length does not match last position");

	// Channel messages are at most three bytes long.
	a_chan_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_sysex |-> (position <= 12'd2))
		else $error("channel message byte beyond position 2");

	// Every message opens with a status byte.
	a_status_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (position == 12'd0) |-> data_byte[7])
		else $error("message opens without a status byte");

	// A stalled request holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(position))
		else $error("stalled request changed");
endmodule

bind midi_tx_message_framer mtf_checker u_mtf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (msg_out.valid),
	.out_ready  (msg_out.ready),
	.data_byte  (msg_out.data_byte),
	.position   (msg_out.position),
	.is_last    (msg_out.is_last),
	.msg_length (msg_out.msg_length),
	.is_sysex   (msg_out.is_sysex)
);

### verif/mtf_frame_checker.sv
module mtf_frame_checker
	import mtf_pkg::*;
#(
	parameter int unsigned MAX_SYSEX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	mtf_byte_if         byte_ch,
	mtf_msg_if          msg_ch,
	output int unsigned fail_count,
	output int unsigned predicted_count,
	output int unsigned backlog
);

	// A system-exclusive message never runs past the widest length the fields carry,
	// and a single start byte can never close one.
	localparam int unsigned SYSEX_CAP = (MAX_SYSEX > LEN_CEIL) ? LEN_CEIL :
		((MAX_SYSEX < 2) ? 2 : MAX_SYSEX);

	phase_t      phase;
	logic        expect_three;
	logic [12:0] byte_count;
	result_t     frames_due[$];
	int unsigned mismatches = 0;
	int unsigned framed = 0;

	task automatic queue_frame(input logic [7:0] b, input logic [11:0] pos, input logic last,
		input logic [12:0] len, input logic sx);
		result_t r;
		r.data_byte  = b;
		r.position   = pos;
		r.is_last    = last;
		r.msg_length = len;
		r.is_sysex   = sx;
		frames_due.push_back(r);
		framed++;
	endtask

	task automatic frame_byte(input logic [7:0] b);
		logic [12:0] pos;
		logic [12:0] len;
		case (phase)
			PH_IDLE: begin
				case (b[7:4])
					NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRESS, NIB_CTRL, NIB_PITCH: begin
						expect_three = 1'b1;
						phase = PH_DATA1;
						queue_frame(b, 12'd0, 1'b0, 13'd0, 1'b0);
					end
					NIB_PROG, NIB_CHAN_PRESS: begin
						expect_three = 1'b0;
						phase = PH_DATA1;
						queue_frame(b, 12'd0, 1'b0, 13'd0, 1'b0);
					end
					default: begin
						if (b == SYSEX_START) begin
							phase = PH_SYSEX;
							byte_count = 13'd1;
							queue_frame(b, 12'd0, 1'b0, 13'd0, 1'b1);
						end
					end
				endcase
			end
			PH_DATA1: begin
				if (expect_three) begin
					phase = PH_DATA2;
					queue_frame(b, 12'd1, 1'b0, 13'd0, 1'b0);
				end else begin
					phase = PH_IDLE;
					queue_frame(b, 12'd1, 1'b1, 13'd2, 1'b0);
				end
			end
			PH_DATA2: begin
				phase = PH_IDLE;
				queue_frame(b, 12'd2, 1'b1, 13'd3, 1'b0);
			end
			default: begin
				if (!b[7] || b == SYSEX_END) begin
					pos = (byte_count > LEN_CEIL - 1) ? 13'(LEN_CEIL - 1) : byte_count;
					len = pos + 13'd1;
					if (b == SYSEX_END || len >= SYSEX_CAP) begin
						phase = PH_IDLE;
						byte_count = 13'd0;
						queue_frame(b, pos[11:0], 1'b1, len, 1'b1);
					end else begin
						byte_count = len;
						queue_frame(b, pos[11:0], 1'b0, 13'd0, 1'b1);
					end
				end
			end
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_frame();
		result_t want;
		if (frames_due.size() == 0) begin
			$display("%0t: unexpected byte 0x%0h at position %0d, expected nothing", $time,
				msg_ch.data_byte, msg_ch.position);
			mismatches++;
		end else begin
			want = frames_due.pop_front();
			check_field("data_byte", want.data_byte, msg_ch.data_byte);
			check_field("position", want.position, msg_ch.position);
			check_field("is_last", want.is_last, msg_ch.is_last);
			check_field("msg_length", want.msg_length, msg_ch.msg_length);
			check_field("is_sysex", want.is_sysex, msg_ch.is_sysex);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			expect_three = 1'b0;
			byte_count = 13'd0;
			frames_due.delete();
			backlog <= 0;
			fail_count <= 0;
			predicted_count <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				frame_byte(byte_ch.in_byte);
			if (msg_ch.valid && msg_ch.ready)
				check_frame();
			backlog <= frames_due.size();
			fail_count <= mismatches;
			predicted_count <= framed;
		end
	end

endmodule

### verif/tb_midi_tx_message_framer.sv
module tb_midi_tx_message_framer;
	import mtf_pkg::*;

	// Full-length system-exclusive limit, the default of the block.
	localparam int unsigned MAX_SYSEX = 4096;
	// Cycles with no request on either channel before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 2000;
	// Margin waited after the last due result has been checked.
	localparam int unsigned DRAIN_CYCLES = 8;
	// Timing clock, a real-time byte that may show up anywhere in the stream.
	localparam logic [7:0] RT_TIMING_CLOCK = 8'hF8;

	logic clk;
	logic arst_n;

	mtf_byte_if byte_ch();
	mtf_msg_if  msg_ch();

	int unsigned fail_count;
	int unsigned predicted_count;
	int unsigned backlog;

	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned quiet_cycles = 0;

	// Directed opening: dropped idle bytes, five of the seven channel message
	// classes with their field extremes, status bytes taken as data, an empty
	// system-exclusive message and one with stray status bytes that must be skipped.
	logic [7:0] directed_stream [24] = '{
		8'h00, SYSEX_END, 8'hFF,
		{NIB_NOTE_OFF, 4'h0}, 8'h00, 8'h7F,
		{NIB_NOTE_ON, 4'hF}, 8'hFF, 8'h80,
		{NIB_PITCH, 4'hF}, 8'h7F, 8'h00,
		{NIB_PROG, 4'h0}, 8'hFF,
		{NIB_CHAN_PRESS, 4'hF}, 8'h00,
		SYSEX_START, SYSEX_END,
		SYSEX_START, 8'h7F, RT_TIMING_CLOCK, SYSEX_START, 8'h00, SYSEX_END
	};

	midi_tx_message_framer #(
		.MAX_SYSEX(MAX_SYSEX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_ch),
		.msg_out(msg_ch)
	);

	mtf_frame_checker #(
		.MAX_SYSEX(MAX_SYSEX)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.msg_ch(msg_ch),
		.fail_count(fail_count),
		.predicted_count(predicted_count),
		.backlog(backlog)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The receiver drops ready at random in the current stall ratio; with a ratio
	// of zero it takes every request as soon as it is offered.
	always @(posedge clk) begin
		msg_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Watchdog: any request on either side counts as progress. Bytes that the
	// framer drops still complete a request on byte_in, so they keep it quiet too.
	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) || (msg_ch.valid && msg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request for %0d cycles, %0d results still due", $time,
					quiet_cycles, backlog);
				$display("midi_tx_message_framer: mismatch");
				$finish;
			end
		end
	end

	// Offers one byte on byte_in, after a random number of idle cycles, and
	// returns at the edge where the request completes. valid stays high on the
	// way out so that back-to-back bytes go through without a bubble.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.in_byte <= b;
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	// Mostly seven-bit data, but now and then any byte: after a channel status
	// the framer takes whatever comes as data.
	function automatic logic [7:0] data_value();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(127));
	endfunction

	function automatic logic [7:0] channel_status(input logic three_bytes);
		logic [3:0] nib;
		if (three_bytes) begin
			case ($urandom_range(4))
				0: nib = NIB_NOTE_OFF;
				1: nib = NIB_NOTE_ON;
				2: nib = NIB_POLY_PRESS;
				3: nib = NIB_CTRL;
				default: nib = NIB_PITCH;
			endcase
		end else begin
			nib = ($urandom_range(1) == 0) ? NIB_PROG : NIB_CHAN_PRESS;
		end
		return {nib, 4'($urandom_range(15))};
	endfunction

	// A status byte that lands inside system-exclusive and must be skipped;
	// the end marker is swapped for a timing clock so the message stays open.
	function automatic logic [7:0] stray_status();
		logic [7:0] b;
		b = 8'($urandom_range(255, 128));
		if (b == SYSEX_END)
			b = RT_TIMING_CLOCK;
		return b;
	endfunction

	// One slice of traffic: mostly well-formed messages with random content,
	// plus loose bytes and system-exclusive messages that are never closed,
	// which then swallow whatever follows until an end marker turns up.
	task automatic send_message();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 15) begin
			send_byte(8'($urandom_range(255)));
		end else if (pick < 45) begin
			send_byte(channel_status(1'b1));
			send_byte(data_value());
			send_byte(data_value());
		end else if (pick < 65) begin
			send_byte(channel_status(1'b0));
			send_byte(data_value());
		end else begin
			n = $urandom_range(20);
			send_byte(SYSEX_START);
			repeat (n) begin
				if ($urandom_range(9) == 0)
					send_byte(stray_status());
				send_byte(8'($urandom_range(127)));
			end
			if ($urandom_range(9) != 0)
				send_byte(SYSEX_END);
		end
	endtask

	// Runs random traffic under one idling pattern until enough stream bytes
	// have been sent, dropped ones included.
	task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
		input int unsigned stream_bytes);
		int unsigned start;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		start = bytes_sent;
		while (bytes_sent - start < stream_bytes)
			send_message();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = 8'h00;
		msg_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_stream[i])
			send_byte(directed_stream[i]);

		// Sender light and receiver heavy, then the other way round, then flat out.
		run_phase(14, 51, 592);
		run_phase(51, 14, 592);
		run_phase(0, 0, 592);

		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d stream bytes: directed extremes, random channel, program and",
			bytes_sent);
		$display("system-exclusive traffic with noise under three idling patterns,");
		$display("%0d results checked.", predicted_count);
		if (fail_count == 0) begin
			$display("midi_tx_message_framer: match");
		end else begin
			$display("midi_tx_message_framer: mismatch");
		end
		$finish;
	end

endmodule
